// File: src/qap_glb_cost_matrix_top_assert.svh
// Assertion macros for the cost matrix RTL.
`ifndef QAP_GLB_COST_MATRIX_TOP_ASSERT_SVH
`define QAP_GLB_COST_MATRIX_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define QGCM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define QGCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QGCM_ASSERT_SAME(label, ante, cons)
`define QGCM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: src/qgcm_pkg.sv
// Types and constants for the cost matrix row builder.
package qgcm_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_DECIDE,
        ST_SEEK,
        ST_MIN,
        ST_SUM,
        ST_OUT
    } state_t;

    localparam logic [1:0] KIND_DIST    = 2'd0;
    localparam logic [1:0] KIND_FLOW    = 2'd1;
    localparam logic [1:0] KIND_PLACE   = 2'd2;
    localparam logic [1:0] KIND_COMPUTE = 2'd3;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BOUND  = 2'd1;
    localparam logic [1:0] STATUS_PLACED = 2'd2;

    localparam logic [6:0] PLACE_NONE = 7'h7F;
    localparam logic [4:0] CFG_RESET  = 5'd16;
    localparam logic [16:0] DMIN_NONE = 17'h10000;

endpackage

// File: src/qap_glb_cost_matrix_top.sv
// Gilmore-Lawler cost row builder: stores, control sequencer and output register.
//
// Kinds 0..2 (distance, flow, placement writes) are each taken while idle. A
// compute request first counts the unassigned facilities and free locations over
// max(MAX_FACILITIES, MAX_LOCATIONS) entries, then for each free location k finds
// the least distance to another free location and accumulates flow-times-distance
// products, after a seek step to find k, and then transfers its result. Both the
// minimum search and the product sum go through the single read port of the
// distance memory, one word a cycle. One item is worked on at a time; input is
// taken only when idle. A row that fails the bound or placement check gives one
// entry with an error status instead.
`include "qap_glb_cost_matrix_top_assert.svh"
module qap_glb_cost_matrix_top #(
    parameter int MAX_FACILITIES = 16,
    parameter int MAX_LOCATIONS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [5:0]         row_index,
    input  logic [5:0]         col_index,
    input  logic [15:0]        weight,
    input  logic signed [6:0]  placed_location,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [5:0]         location_index,
    output logic [37:0]        row_cost,
    output logic [1:0]         status,
    output logic               last
);
    import qgcm_pkg::*;

    localparam int FW   = $clog2(MAX_FACILITIES);
    localparam int LW   = $clog2(MAX_LOCATIONS);
    localparam int CMAX = (MAX_FACILITIES > MAX_LOCATIONS) ? MAX_FACILITIES : MAX_LOCATIONS;
    localparam int CW   = $clog2(CMAX + 1);
    localparam int UW   = $clog2(MAX_FACILITIES + 1);
    localparam int DAW  = $clog2(MAX_LOCATIONS * MAX_LOCATIONS);
    localparam int FAW  = $clog2(MAX_FACILITIES * MAX_FACILITIES);

    // Stores
    logic [15:0] dist_mem [MAX_LOCATIONS * MAX_LOCATIONS];
    logic [15:0] flow_mem [MAX_FACILITIES * MAX_FACILITIES];
    logic [6:0]  place_reg [MAX_FACILITIES];
    logic [UW-1:0] use_cnt_reg [MAX_LOCATIONS];

    logic [4:0]  nf_reg, nl_reg;
    state_t      state_reg, state_next;
    logic [CW-1:0] cnt_reg, k_reg, u_reg, r_reg;
    logic [5:0]  row_reg;
    logic [FW-1:0] fac_reg;
    logic [16:0] dmin_reg;
    logic        pend_reg;
    logic        s1_reg, s1_min_reg, s1_fix_reg, s2_reg;
    logic [31:0] prod_reg;
    logic [37:0] acc_reg;
    logic [15:0] dist_rd_reg, flow_rd_reg;

    logic        out_valid_reg;
    logic [5:0]  loc_reg;
    logic [37:0] cost_reg;
    logic [1:0]  status_reg;
    logic        last_reg;

    logic [CW-1:0] eff_n, eff_m;
    logic        in_xfer, out_xfer, cfg_wr;
    logic [MAX_LOCATIONS-1:0] used;
    logic        more_free;
    logic [DAW-1:0] dist_raddr;
    logic [FAW-1:0] flow_raddr;
    logic        min_issue, sum_issue, iss_min, iss_fix;
    logic [6:0]  cur_place;
    logic        place_ok, row_ok;
    logic [15:0] op_b;
    logic        op_en;
    logic        err_bound, err_placed;

    // Handshakes
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign location_index = loc_reg;
    assign row_cost  = cost_reg;
    assign status    = status_reg;
    assign last      = last_reg;
    assign prdata    = paddr[2] ? {27'd0, nl_reg} : {27'd0, nf_reg};

    // Clamp configured sizes to the built capacity
    assign eff_n = (7'(nf_reg) > 7'(MAX_FACILITIES)) ? CW'(MAX_FACILITIES) : CW'(nf_reg);
    assign eff_m = (7'(nl_reg) > 7'(MAX_LOCATIONS)) ? CW'(MAX_LOCATIONS) : CW'(nl_reg);

    // Location occupancy and free locations after the current one
    always_comb
    begin
        more_free = 1'b0;
        for (int l = 0; l < MAX_LOCATIONS; l++) begin
            used[l] = (use_cnt_reg[l] != '0);
            if ((CW'(l) > k_reg) && (CW'(l) < eff_m) && (use_cnt_reg[l] == '0))
                more_free = 1'b1;
        end
    end

    // Placement write qualification
    assign row_ok   = (7'(row_index) < 7'(MAX_FACILITIES));
    assign place_ok = (placed_location == $signed(PLACE_NONE)) ||
                      (!placed_location[6] &&
                       ({1'b0, placed_location[5:0]} < 7'(MAX_LOCATIONS)));

    // Bounding checks
    assign err_bound  = (7'(row_reg) >= 7'(eff_n)) || (u_reg == '0) || (r_reg < u_reg);
    assign err_placed = (place_reg[row_reg[FW-1:0]] != PLACE_NONE);

    // Memory read control
    always_comb
    begin
        cur_place  = place_reg[cnt_reg[FW-1:0]];
        min_issue  = (state_reg == ST_MIN) && (cnt_reg < eff_m);
        sum_issue  = (state_reg == ST_SUM) && (cnt_reg < eff_n);
        iss_min    = (cur_place == PLACE_NONE) && (cnt_reg[FW-1:0] != fac_reg);
        iss_fix    = (cur_place != PLACE_NONE);
        flow_raddr = FAW'(32'(fac_reg) * MAX_FACILITIES + 32'(cnt_reg));
        if (state_reg == ST_SUM)
            dist_raddr = DAW'(32'(k_reg) * MAX_LOCATIONS + 32'(cur_place[LW-1:0]));
        else
            dist_raddr = DAW'(32'(k_reg) * MAX_LOCATIONS + 32'(cnt_reg));
        op_b  = s1_min_reg ? dmin_reg[15:0] : dist_rd_reg;
        op_en = s1_fix_reg || (s1_min_reg && !dmin_reg[16]);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer && kind == KIND_COMPUTE)
                    state_next = ST_COUNT;
            ST_COUNT:
                if (cnt_reg == CW'(CMAX - 1))
                    state_next = ST_DECIDE;
            ST_DECIDE:
                state_next = (err_bound || err_placed) ? ST_OUT : ST_SEEK;
            ST_SEEK:
                if (k_reg >= eff_m)
                    state_next = ST_IDLE;
                else if (!used[k_reg[LW-1:0]])
                    state_next = ST_MIN;
            ST_MIN:
                if (cnt_reg >= eff_m)
                    state_next = ST_SUM;
            ST_SUM:
                if (cnt_reg >= eff_n && !s1_reg && !s2_reg)
                    state_next = ST_OUT;
            ST_OUT:
                if (out_xfer)
                    state_next = last_reg ? ST_IDLE : ST_SEEK;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            nf_reg        <= CFG_RESET;
            nl_reg        <= CFG_RESET;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            s1_reg        <= 1'b0;
            s2_reg        <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
            u_reg         <= '0;
            r_reg         <= '0;
            for (int f = 0; f < MAX_FACILITIES; f++)
                place_reg[f] <= PLACE_NONE;
            for (int l = 0; l < MAX_LOCATIONS; l++)
                use_cnt_reg[l] <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // Hold configuration
            if (cfg_wr)
            begin
                if (paddr[2])
                    nl_reg <= pwdata[4:0];
                else
                    nf_reg <= pwdata[4:0];
            end

            // Move placement and keep per-location occupancy counts
            if (in_xfer && kind == KIND_PLACE && row_ok && place_ok)
            begin
                place_reg[row_index[FW-1:0]] <= placed_location;
                for (int l = 0; l < MAX_LOCATIONS; l++) begin
                    if ((placed_location != $signed(PLACE_NONE)) &&
                        (7'(placed_location) == 7'(l)) &&
                        !((place_reg[row_index[FW-1:0]] != PLACE_NONE) &&
                          (place_reg[row_index[FW-1:0]] == 7'(l))))
                        use_cnt_reg[l] <= use_cnt_reg[l] + UW'(1);
                    else if ((place_reg[row_index[FW-1:0]] != PLACE_NONE) &&
                             (place_reg[row_index[FW-1:0]] == 7'(l)) &&
                             !((placed_location != $signed(PLACE_NONE)) &&
                               (7'(placed_location) == 7'(l))))
                        use_cnt_reg[l] <= use_cnt_reg[l] - UW'(1);
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    u_reg   <= '0;
                    r_reg   <= '0;
                end
                ST_COUNT:
                begin
                    // Count unassigned facilities and free locations
                    if (cnt_reg < eff_n && place_reg[cnt_reg[FW-1:0]] == PLACE_NONE)
                        u_reg <= u_reg + CW'(1);
                    if (cnt_reg < eff_m && !used[cnt_reg[LW-1:0]])
                        r_reg <= r_reg + CW'(1);
                    cnt_reg <= cnt_reg + CW'(1);
                end
                ST_DECIDE:
                begin
                    fac_reg <= row_reg[FW-1:0];
                    k_reg   <= '0;
                    if (err_bound || err_placed)
                    begin
                        out_valid_reg <= 1'b1;
                        loc_reg       <= '0;
                        cost_reg      <= '0;
                        status_reg    <= err_bound ? STATUS_BOUND : STATUS_PLACED;
                        last_reg      <= 1'b1;
                    end
                end
                ST_SEEK:
                begin
                    cnt_reg  <= '0;
                    dmin_reg <= DMIN_NONE;
                    pend_reg <= 1'b0;
                    if (k_reg < eff_m && used[k_reg[LW-1:0]])
                        k_reg <= k_reg + CW'(1);
                end
                ST_MIN:
                begin
                    // Track least distance to another free location
                    if (pend_reg && {1'b0, dist_rd_reg} < dmin_reg)
                        dmin_reg <= {1'b0, dist_rd_reg};
                    pend_reg <= min_issue && (cnt_reg != k_reg) && !used[cnt_reg[LW-1:0]];
                    if (min_issue)
                        cnt_reg <= cnt_reg + CW'(1);
                    else
                    begin
                        cnt_reg <= '0;
                        acc_reg <= '0;
                        s1_reg  <= 1'b0;
                        s2_reg  <= 1'b0;
                    end
                end
                ST_SUM:
                begin
                    // Issue reads, multiply, accumulate
                    s1_reg     <= sum_issue;
                    s1_min_reg <= iss_min;
                    s1_fix_reg <= iss_fix;
                    s2_reg     <= s1_reg && op_en;
                    prod_reg   <= flow_rd_reg * op_b;
                    if (s2_reg)
                        acc_reg <= acc_reg + 38'(prod_reg);
                    if (sum_issue)
                        cnt_reg <= cnt_reg + CW'(1);
                    if (state_next == ST_OUT)
                    begin
                        out_valid_reg <= 1'b1;
                        loc_reg       <= 6'(k_reg);
                        cost_reg      <= s2_reg ? acc_reg + 38'(prod_reg) : acc_reg;
                        status_reg    <= STATUS_OK;
                        last_reg      <= !more_free;
                    end
                end
                ST_OUT:
                begin
                    if (out_xfer)
                    begin
                        out_valid_reg <= 1'b0;
                        k_reg         <= k_reg + CW'(1);
                    end
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // Capture the compute row
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            row_reg <= row_index;
    end

    // Distance and flow memories, registered read
    always_ff @(posedge clk)
    begin
        if (in_xfer && kind == KIND_DIST &&
            7'(row_index) < 7'(MAX_LOCATIONS) && 7'(col_index) < 7'(MAX_LOCATIONS))
            dist_mem[DAW'(32'(row_index) * MAX_LOCATIONS + 32'(col_index))] <= weight;
        if (in_xfer && kind == KIND_FLOW &&
            7'(row_index) < 7'(MAX_FACILITIES) && 7'(col_index) < 7'(MAX_FACILITIES))
            flow_mem[FAW'(32'(row_index) * MAX_FACILITIES + 32'(col_index))] <= weight;
        dist_rd_reg <= dist_mem[dist_raddr];
        flow_rd_reg <= flow_mem[flow_raddr];
    end

    `QGCM_ASSERT_SAME(a_out_blocks_in, out_valid_reg, !in_ready)
    `QGCM_ASSERT_SAME(a_err_is_last, out_valid_reg && status_reg != STATUS_OK, last_reg)
    `QGCM_ASSERT_SAME(a_sum_in_phase, s2_reg, state_reg == ST_SUM || state_reg == ST_OUT)
    `QGCM_ASSERT_NEXT(a_last_to_idle, state_reg == ST_OUT && out_xfer && last_reg,
                      state_reg == ST_IDLE && !out_valid_reg)

endmodule

// File: tb/sv/qap_glb_cost_matrix_top_tb.sv
// Self-checking testbench for the Gilmore-Lawler cost row builder.
`timescale 1ns / 100ps
module qap_glb_cost_matrix_top_tb;
    import qgcm_pkg::*;

    localparam int NF = 16;
    localparam int NL = 16;
    localparam logic [2:0] ADDR_NUM_FAC = 3'd0;
    localparam logic [2:0] ADDR_NUM_LOC = 3'd4;
    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0]        kind;
        logic [5:0]        row;
        logic [5:0]        col;
        logic [15:0]       weight;
        logic signed [6:0] ploc;
    } cmd_t;

    typedef struct packed {
        logic [5:0]  loc;
        logic [37:0] cost;
        logic [1:0]  status;
        logic        last;
    } cost_entry_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready;
    logic [1:0] kind;
    logic [5:0] row_index, col_index;
    logic [15:0] weight;
    logic signed [6:0] placed_location;
    logic out_valid, out_ready;
    logic [5:0] location_index;
    logic [37:0] row_cost;
    logic [1:0] status;
    logic last;

    qap_glb_cost_matrix_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .row_index(row_index), .col_index(col_index), .weight(weight),
        .placed_location(placed_location),
        .out_valid(out_valid), .out_ready(out_ready),
        .location_index(location_index), .row_cost(row_cost),
        .status(status), .last(last)
    );

    // shadow of the block state
    logic [15:0] dist_mem [NL][NL];
    logic [15:0] flow_mem [NF][NF];
    bit          dist_written [NL][NL];
    bit          flow_written [NF][NF];
    int          facility_place [NF];
    int          fac_count;
    int          loc_count;

    cmd_t        cmd_queue[$];
    cost_entry_t cost_queue[$];
    int          fail_count;
    bit          idle_on;

    function automatic bit loc_taken(int l);
        bit t;
        t = 0;
        for (int f = 0; f < NF; f++)
            if (facility_place[f] == l)
                t = 1;
        return t;
    endfunction

    function automatic logic [15:0] rand_weight();
        return ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    endfunction

    // update shadow state and queue the cost entries a command causes
    task automatic predict_cost_row(cmd_t c);
        int n, m, u, r, p;
        logic [16:0] dmin;
        logic [63:0] acc;
        cost_entry_t e;
        int last_idx;
        n = (fac_count > NF) ? NF : fac_count;
        m = (loc_count > NL) ? NL : loc_count;
        case (c.kind)
            KIND_DIST:
                if (c.row < NL && c.col < NL)
                begin
                    dist_mem[c.row][c.col] = c.weight;
                    dist_written[c.row][c.col] = 1;
                end
            KIND_FLOW:
                if (c.row < NF && c.col < NF)
                begin
                    flow_mem[c.row][c.col] = c.weight;
                    flow_written[c.row][c.col] = 1;
                end
            KIND_PLACE:
                if (c.row < NF && (c.ploc == -1 || (c.ploc >= 0 && c.ploc < NL)))
                    facility_place[c.row] = c.ploc;
            default:
            begin
                u = 0;
                r = 0;
                for (int f = 0; f < n; f++)
                    if (facility_place[f] == -1)
                        u++;
                for (int k = 0; k < m; k++)
                    if (!loc_taken(k))
                        r++;
                e = '0;
                e.last = 1;
                if (c.row >= n || u == 0 || r < u)
                begin
                    e.status = STATUS_BOUND;
                    cost_queue = {cost_queue, e};
                end
                else if (facility_place[c.row] != -1)
                begin
                    e.status = STATUS_PLACED;
                    cost_queue = {cost_queue, e};
                end
                else
                begin
                    for (int k = 0; k < m; k++)
                    begin
                        if (loc_taken(k))
                            continue;
                        dmin = DMIN_NONE;
                        for (int l = 0; l < m; l++)
                            if (l != k && !loc_taken(l) && dist_mem[k][l] < dmin)
                                dmin = {1'b0, dist_mem[k][l]};
                        acc = 0;
                        for (int f = 0; f < n; f++)
                        begin
                            p = facility_place[f];
                            if (p == -1)
                            begin
                                if (f != c.row && dmin <= 17'hFFFF)
                                    acc += 64'(flow_mem[c.row][f]) * 64'(dmin);
                            end
                            else
                                acc += 64'(flow_mem[c.row][f]) * 64'(dist_mem[k][p]);
                        end
                        e.loc = 6'(k);
                        e.cost = acc[37:0];
                        e.status = STATUS_OK;
                        e.last = 0;
                        cost_queue = {cost_queue, e};
                    end
                    last_idx = cost_queue.size() - 1;
                    cost_queue[last_idx].last = 1;
                end
            end
        endcase
    endtask

    task automatic queue_cmd(cmd_t c);
        predict_cost_row(c);
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic queue_store_write(logic [1:0] k, int a, int b);
        cmd_t c;
        c = '0;
        c.kind = k;
        c.row = 6'(a);
        c.col = 6'(b);
        c.weight = rand_weight();
        c.ploc = 7'($urandom);
        queue_cmd(c);
    endtask

    // load every store entry that a good row would read, then request the row
    task automatic queue_compute(int fac);
        cmd_t c;
        int n, m, p;
        n = (fac_count > NF) ? NF : fac_count;
        m = (loc_count > NL) ? NL : loc_count;
        if (fac < n && facility_place[fac] == -1)
        begin
            for (int k = 0; k < m; k++)
            begin
                if (loc_taken(k))
                    continue;
                for (int l = 0; l < m; l++)
                    if (l != k && !loc_taken(l) && !dist_written[k][l])
                        queue_store_write(KIND_DIST, k, l);
                for (int f = 0; f < n; f++)
                begin
                    p = facility_place[f];
                    if (p != -1 && !dist_written[k][p])
                        queue_store_write(KIND_DIST, k, p);
                end
            end
            for (int f = 0; f < n; f++)
                if (!flow_written[fac][f])
                    queue_store_write(KIND_FLOW, fac, f);
        end
        c = '0;
        c.kind = KIND_COMPUTE;
        c.row = 6'(fac);
        c.col = 6'($urandom);
        c.weight = 16'($urandom);
        c.ploc = 7'($urandom);
        queue_cmd(c);
    endtask

    task automatic queue_place(int fac, int l);
        cmd_t c;
        c = '0;
        c.kind = KIND_PLACE;
        c.row = 6'(fac);
        c.col = 6'($urandom);
        c.weight = 16'($urandom);
        c.ploc = 7'(l);
        queue_cmd(c);
    endtask

    task automatic queue_random_cmd();
        int sel, n, m, fac, l, tries;
        n = (fac_count > NF) ? NF : fac_count;
        m = (loc_count > NL) ? NL : loc_count;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            queue_store_write(KIND_DIST,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NL - 1),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NL - 1));
        else if (sel < 5)
            queue_store_write(KIND_FLOW,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NF - 1),
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, NF - 1));
        else if (sel < 7)
        begin
            fac = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
            case ($urandom_range(0, 7))
                0, 1:    l = -1;
                2:       l = $urandom_range(0, 127) - 64;
                3:       l = $urandom_range(0, NL - 1);
                default: l = $urandom_range(0, m - 1);
            endcase
            queue_place(fac, l);
        end
        else
        begin
            // prefer an unassigned facility so most rows succeed
            fac = $urandom_range(0, n - 1);
            tries = 0;
            while (facility_place[fac] != -1 && tries < 8)
            begin
                fac = $urandom_range(0, n - 1);
                tries++;
            end
            if ($urandom_range(0, 9) == 0)
                fac = $urandom_range(0, 63);
            queue_compute(fac);
        end
    endtask

    task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        if (addr == ADDR_NUM_FAC)
            fac_count = data[4:0];
        else
            loc_count = data[4:0];
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() != 0 || in_valid || cost_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(int nf, int nl, bit quiet, int n_rand);
        cfg_write(ADDR_NUM_FAC, 32'(nf));
        cfg_write(ADDR_NUM_LOC, 32'(nl));
        idle_on = !quiet;
        for (int i = 0; i < n_rand; i++)
            queue_random_cmd();
        wait_drained();
    endtask

    // clock
    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // input driver: present queued commands with random gaps
    int gap_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        cmd_t c;
        if (!rst_n)
        begin
            in_valid <= 0;
            gap_cnt <= 0;
        end
        else if ((in_valid && in_ready) || !in_valid)
        begin
            if (in_valid && in_ready && idle_on && $urandom_range(0, 1) == 1)
            begin
                in_valid <= 0;
                gap_cnt <= $urandom_range(0, 5);
            end
            else if (gap_cnt > 0)
            begin
                in_valid <= 0;
                gap_cnt <= gap_cnt - 1;
            end
            else if (cmd_queue.size() != 0)
            begin
                c = cmd_queue.pop_front();
                in_valid <= 1;
                kind <= c.kind;
                row_index <= c.row;
                col_index <= c.col;
                weight <= c.weight;
                placed_location <= c.ploc;
            end
            else
                in_valid <= 0;
        end
    end

    // result monitor: random backpressure, compare each transfer
    int stall_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        cost_entry_t exp_e;
        if (!rst_n)
        begin
            out_ready <= 0;
            stall_cnt <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (cost_queue.size() == 0)
                begin
                    $display("%0t: unexpected transfer loc=%0d cost=%0d status=%0d last=%0d",
                             $time, location_index, row_cost, status, last);
                    fail_count++;
                end
                else
                begin
                    exp_e = cost_queue.pop_front();
                    if (exp_e.loc !== location_index)
                    begin
                        $display("%0t: location_index expected %0d actual %0d",
                                 $time, exp_e.loc, location_index);
                        fail_count++;
                    end
                    if (exp_e.cost !== row_cost)
                    begin
                        $display("%0t: row_cost expected %0d actual %0d",
                                 $time, exp_e.cost, row_cost);
                        fail_count++;
                    end
                    if (exp_e.status !== status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, exp_e.status, status);
                        fail_count++;
                    end
                    if (exp_e.last !== last)
                    begin
                        $display("%0t: last expected %0d actual %0d",
                                 $time, exp_e.last, last);
                        fail_count++;
                    end
                end
                stall_cnt <= idle_on ? $urandom_range(0, 5) : 0;
                out_ready <= !idle_on;
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                out_ready <= 0;
            end
            else
                out_ready <= 1;
        end
    end

    // watchdog: end the run when nothing transfers for too long
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cmd_queue.size() == 0 && !in_valid && cost_queue.size() == 0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // stimulus
    initial
    begin
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        kind = '0;
        row_index = '0;
        col_index = '0;
        weight = '0;
        placed_location = '0;
        fail_count = 0;
        idle_on = 0;
        quiet_cycles = 0;
        fac_count = 16;
        loc_count = 16;
        for (int f = 0; f < NF; f++)
            facility_place[f] = -1;
        for (int a = 0; a < NL; a++)
            for (int b = 0; b < NL; b++)
            begin
                dist_mem[a][b] = '0;
                dist_written[a][b] = 0;
            end
        for (int a = 0; a < NF; a++)
            for (int b = 0; b < NF; b++)
            begin
                flow_mem[a][b] = '0;
                flow_written[a][b] = 0;
            end
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // small row with every facility unassigned, then the edge cases
        cfg_write(ADDR_NUM_FAC, 32'd4);
        cfg_write(ADDR_NUM_LOC, 32'd5);
        idle_on = 1;
        queue_compute(0);
        queue_compute(63);                // facility beyond n
        queue_place(40, 3);               // facility out of range, dropped
        queue_place(1, 63);               // location out of range, dropped
        queue_place(1, -64);              // negative junk location, dropped
        queue_store_write(KIND_DIST, 63, 2);
        queue_store_write(KIND_FLOW, 5, 63);
        queue_place(1, 2);
        queue_compute(1);                 // facility already placed
        queue_place(2, 2);                // shared location
        queue_compute(3);
        queue_place(1, -1);
        queue_place(2, -1);
        wait_drained();

        // single facility and location: placed facility leaves none unassigned
        cfg_write(ADDR_NUM_FAC, 32'd1);
        cfg_write(ADDR_NUM_LOC, 32'd1);
        queue_compute(0);
        queue_place(0, 0);
        queue_compute(0);
        queue_place(0, -1);
        wait_drained();

        // fewer free locations than unassigned facilities
        cfg_write(ADDR_NUM_FAC, 32'd3);
        cfg_write(ADDR_NUM_LOC, 32'd2);
        queue_compute(0);
        wait_drained();

        // placement beyond num_locations is stored but never free
        cfg_write(ADDR_NUM_FAC, 32'd3);
        cfg_write(ADDR_NUM_LOC, 32'd5);
        queue_place(1, 10);
        queue_compute(0);
        queue_place(1, -1);
        wait_drained();

        // sizes above capacity clamp: facility 17 lies beyond the clamped n
        cfg_write(ADDR_NUM_FAC, 32'd20);
        cfg_write(ADDR_NUM_LOC, 32'd31);
        queue_compute(17);
        wait_drained();

        run_phase(4, 6, 0, 14);
        run_phase(6, 4, 1, 12);

        if (fail_count == 0 && cost_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/qgcm_pkg.sv
src/qap_glb_cost_matrix_top.sv
tb/sv/qap_glb_cost_matrix_top_tb.sv
